/* rtl/bmp_pkg.sv */
// Shared types and constants for the BMP raster decoder.
// No dependencies.
package bmp_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam logic [1:0] MODE_PAL8   = 2'd0;
  localparam logic [1:0] MODE_RLE8   = 2'd1;
  localparam logic [1:0] MODE_RGB555 = 2'd2;
  localparam logic [1:0] MODE_BGR24  = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [2:0] PH_COUNT    = 3'd0;
  localparam logic [2:0] PH_VALUE    = 3'd1;
  localparam logic [2:0] PH_DELTA_X  = 3'd2;
  localparam logic [2:0] PH_DELTA_Y  = 3'd3;
  localparam logic [2:0] PH_ABS_DATA = 3'd4;
  localparam logic [2:0] PH_ABS_PAD  = 3'd5;

  // Color source of a queued span command.
  localparam logic [1:0] SRC_PAL    = 2'd0;
  localparam logic [1:0] SRC_DIRECT = 2'd1;
  localparam logic [1:0] SRC_BLACK  = 2'd2;

  // Command from the parser to the output stage.
  typedef struct packed {
    logic [1:0]  src;
    logic [7:0]  index;
    logic [23:0] rgb;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  len;
    logic        done;
  } span_cmd_t;

  // Palette write from the front part.
  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [23:0] rgb;
  } pal_wr_t;

endpackage

/* rtl/bmp_parse.sv */
// Front part: byte parser for plain and RLE8 rasters, emits span commands and palette writes.
// Depends on bmp_pkg.
module bmp_parse import bmp_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_byte,
  input  logic [7:0]  in_pidx,
  input  logic [23:0] in_prgb,
  output pal_wr_t     pal_wr,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output span_cmd_t   cmd
);

  localparam logic [12:0] WMAX = 13'(MAX_WIDTH);
  localparam logic [12:0] HMAX = 13'(MAX_HEIGHT);

  logic [1:0]  mode;
  logic [12:0] width_reg, height_reg;
  logic [12:0] w, h;
  logic [2:0]  phase;
  logic [7:0]  held_count, abs_left, delta_right;
  logic        abs_odd, finished;
  logic [12:0] column;
  logic [11:0] row;
  logic [13:0] row_bytes;
  logic [1:0]  bip;
  logic [15:0] held;

  logic [2:0]  phase_next;
  logic [7:0]  held_count_next, abs_left_next, delta_right_next;
  logic        abs_odd_next, finished_next;
  logic [12:0] column_next;
  logic [11:0] row_next;
  logic [13:0] row_bytes_next;
  logic [1:0]  bip_next;
  logic [15:0] held_next;
  logic        emit;
  span_cmd_t   emit_cmd;

  logic [1:0]  bpp;
  logic [15:0] stride;
  logic [12:0] rem, rlen;
  logic [13:0] col_sum;
  logic [7:0]  b, b0, b1;
  logic        cfg_hit;

  assign w = (width_reg == '0) ? 13'd1 : (width_reg > WMAX) ? WMAX : width_reg;
  assign h = (height_reg == '0) ? 13'd1 : (height_reg > HMAX) ? HMAX : height_reg;
  assign bpp = (mode == MODE_PAL8) ? 2'd1 : (mode == MODE_RGB555) ? 2'd2 : 2'd3;
  // Row stride in bytes, rounded up to a word.
  always_comb begin
    logic [15:0] raw;
    raw = 16'(w) * 16'(bpp) + 16'd3;
    stride = {raw[15:2], 2'b00};
  end

  assign in_ready = !cmd_valid || cmd_ready;
  wire take = in_valid && in_ready;

  assign pal_wr.en    = take && in_kind;
  assign pal_wr.index = in_pidx;
  assign pal_wr.rgb   = in_prgb;

  assign b  = in_byte;
  assign b0 = held[7:0];
  assign b1 = held[15:8];
  assign rem  = (column < w) ? w - column : 13'd0;
  assign rlen = (13'(held_count) < rem) ? 13'(held_count) : rem;
  assign col_sum = 14'(column) + 14'(delta_right);

  always_comb begin
    phase_next = phase; held_count_next = held_count; abs_left_next = abs_left;
    abs_odd_next = abs_odd; delta_right_next = delta_right; finished_next = finished;
    column_next = column; row_next = row; row_bytes_next = row_bytes;
    bip_next = bip; held_next = held;
    emit = 1'b0;
    emit_cmd = '0;
    emit_cmd.x = column[11:0];
    emit_cmd.y = row;
    emit_cmd.len = 8'd1;
    emit_cmd.index = b;
    if (!finished && mode == MODE_RLE8) begin
      unique case (phase)
        PH_COUNT: begin
          held_count_next = b;
          phase_next = PH_VALUE;
        end
        PH_VALUE: begin
          phase_next = PH_COUNT;
          if (held_count != 8'd0) begin
            if (rlen != 13'd0) begin
              emit = 1'b1;
              emit_cmd.len = rlen[7:0];
            end
            column_next = column + rlen;
          end else if (b == 8'd0) begin
            column_next = '0;
            if (row == '0) begin
              emit = 1'b1;
              finished_next = 1'b1;
            end else begin
              row_next = row - 12'd1;
            end
          end else if (b == 8'd1) begin
            emit = 1'b1;
            finished_next = 1'b1;
          end else if (b == 8'd2) begin
            phase_next = PH_DELTA_X;
          end else begin
            abs_left_next = b;
            abs_odd_next = b[0];
            phase_next = PH_ABS_DATA;
          end
        end
        PH_DELTA_X: begin
          delta_right_next = b;
          phase_next = PH_DELTA_Y;
        end
        PH_DELTA_Y: begin
          phase_next = PH_COUNT;
          column_next = (col_sum > 14'(w)) ? w : col_sum[12:0];
          if (12'(b) > row) begin
            emit = 1'b1;
            finished_next = 1'b1;
          end else begin
            row_next = row - 12'(b);
          end
        end
        PH_ABS_DATA: begin
          if (column < w) begin
            emit = 1'b1;
            column_next = column + 13'd1;
          end
          abs_left_next = abs_left - 8'd1;
          if (abs_left == 8'd1) phase_next = abs_odd ? PH_ABS_PAD : PH_COUNT;
        end
        default: phase_next = PH_COUNT;
      endcase
      // End markers are black at the origin.
      if (finished_next) begin
        emit_cmd.x = '0; emit_cmd.y = '0; emit_cmd.len = '0;
        emit_cmd.src = SRC_BLACK; emit_cmd.done = 1'b1;
      end
    end else if (!finished) begin
      if (column < w) begin
        if (bip + 2'd1 >= bpp) begin
          emit = 1'b1;
          if (mode == MODE_PAL8) begin
            emit_cmd.src = SRC_PAL;
          end else if (mode == MODE_RGB555) begin
            emit_cmd.src = SRC_DIRECT;
            emit_cmd.rgb = {{b[6:2], 3'b000}, {b[1:0], b0[7:5], 3'b000},
                            {b0[4:0], 3'b000}};
          end else begin
            emit_cmd.src = SRC_DIRECT;
            emit_cmd.rgb = {b, b1, b0};
          end
          if (column + 13'd1 == w && row == '0) begin
            emit_cmd.done = 1'b1;
            finished_next = 1'b1;
          end
          column_next = column + 13'd1;
          bip_next = '0;
          held_next = '0;
        end else begin
          if (bip == 2'd0) held_next = {8'd0, b};
          else held_next = {b, b0};
          bip_next = bip + 2'd1;
        end
      end
      row_bytes_next = row_bytes + 14'd1;
      if (!finished_next && column_next >= w && 16'(row_bytes_next) >= stride) begin
        if (row != '0) row_next = row - 12'd1;
        column_next = '0; row_bytes_next = '0; bip_next = '0; held_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PAL8; width_reg <= 13'd1; height_reg <= 13'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode <= cfg_data[1:0];
        REG_WIDTH:  width_reg <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Any register write restarts the raster; height uses the new value.
  logic [12:0] h_new;
  always_comb begin
    h_new = cfg_data;
    if (h_new == '0) h_new = 13'd1;
    if (h_new > HMAX) h_new = HMAX;
    if (cfg_index != REG_HEIGHT) h_new = h;
  end

  assign cfg_hit = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
                                 cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      phase <= PH_COUNT; held_count <= '0; abs_left <= '0; abs_odd <= 1'b0;
      delta_right <= '0; column <= '0; row_bytes <= '0; bip <= '0; held <= '0;
      finished <= 1'b0;
      row <= rst ? 12'd0 : 12'(h_new - 13'd1);
    end else if (take && !in_kind) begin
      phase <= phase_next; held_count <= held_count_next; abs_left <= abs_left_next;
      abs_odd <= abs_odd_next; delta_right <= delta_right_next;
      column <= column_next; row <= row_next; row_bytes <= row_bytes_next;
      bip <= bip_next; held <= held_next; finished <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cmd_valid <= 1'b0;
    else if (in_ready) cmd_valid <= take && !in_kind && emit;
  end

  always_ff @(posedge clk) begin
    if (in_ready) cmd <= emit_cmd;
  end

endmodule

/* rtl/bmp_out.sv */
// Back part: palette memory, color resolve and output register stage.
// Depends on bmp_pkg.
module bmp_out import bmp_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  pal_wr_t    pal_wr,
  input  logic       in_valid,
  input  span_cmd_t  in_cmd,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output span_cmd_t  out_cmd
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] palette [PALETTE_DEPTH];
  logic [23:0] pal_q;
  logic        idx_ok;
  logic        s_valid;
  span_cmd_t   s_cmd;
  span_cmd_t   s_res;
  logic        s_ok;
  logic        s_ready;

  // Command read of the palette happens as the command enters stage s.
  assign s_ready  = !out_valid || out_ready;
  assign in_ready = !s_valid || s_ready;
  assign idx_ok   = 9'(in_cmd.index) < 9'(PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (pal_wr.en && 9'(pal_wr.index) < 9'(PALETTE_DEPTH))
      palette[pal_wr.index[AW-1:0]] <= pal_wr.rgb;
    if (in_ready) pal_q <= palette[in_cmd.index[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (in_ready) s_valid <= in_valid;
    if (in_ready) begin
      s_cmd <= in_cmd;
      s_ok  <= idx_ok;
    end
  end

  // Final color: palette lookup, direct color, or black.
  always_comb begin
    s_res = s_cmd;
    if (s_cmd.src == SRC_PAL) s_res.rgb = s_ok ? pal_q : 24'd0;
    else if (s_cmd.src == SRC_BLACK) s_res.rgb = 24'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s_ready) out_valid <= s_valid;
    if (s_ready) out_cmd <= s_res;
  end

endmodule

/* rtl/bmp_raster_decoder.sv */
// Top level of the BMP raster decoder: parser front, palette/output back.
// Depends on bmp_pkg, bmp_parse, bmp_out.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: data_byte, palette_index, red, green, blue; tuser: kind
//  m_axis  | out | tdata: x, y, span_length, red, green, blue; tuser: image_done
//  cfg     | in  | index 0 mode, 1 width, 2 height
//
// One beat per cycle sustained while m_axis is ready; a result passes the parse register,
// the palette read register and the output register before it leaves.
// Reset is synchronous; the palette is undefined until written.
// m_axis stalls back-pressure through the output, palette read and parse registers to s_axis_tready.
module bmp_raster_decoder import bmp_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_byte, palette_index, red, green, blue
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // pixel_x, pixel_y, span_length, red, green, blue
  output logic        m_axis_tuser,  // image_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  pal_wr_t   pal_wr;
  logic      cmd_valid, cmd_ready;
  span_cmd_t cmd, ocmd;

  assign cfg_ready = 1'b1;

  bmp_parse #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_parse (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_kind(s_axis_tuser), .in_byte(s_axis_tdata[7:0]),
    .in_pidx(s_axis_tdata[15:8]),
    .in_prgb({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .pal_wr, .cmd_valid, .cmd_ready, .cmd
  );

  bmp_out #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_out (
    .clk, .rst, .pal_wr,
    .in_valid(cmd_valid), .in_cmd(cmd), .in_ready(cmd_ready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_cmd(ocmd)
  );

  assign m_axis_tdata = {ocmd.rgb[7:0], ocmd.rgb[15:8], ocmd.rgb[23:16],
                         ocmd.len, ocmd.y, ocmd.x};
  assign m_axis_tuser = ocmd.done;

endmodule

/* rtl/bmp_checker.sv */
// Port-level checks for the BMP raster decoder, bound to the top level.
// Depends on bmp_raster_decoder ports only.
module bmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[31:24] == 8'd0 |-> m_axis_tuser)
    else $error("zero-length span without done");

  a_marker_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[31:24] == 8'd0 |-> m_axis_tdata[55:32] == 24'd0)
    else $error("end marker not black");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind bmp_raster_decoder bmp_checker u_bmp_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

/* verif/testbench.sv */
// Self-checking testbench for bmp_raster_decoder: palette, RLE8, RGB555 and BGR24 rasters.
// Depends on bmp_pkg and the decoder RTL; a built-in span predictor checks every output beat.
`timescale 1ns / 100ps

module testbench import bmp_pkg::*;;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  pal_idx;
    logic [7:0]  pal_r;
    logic [7:0]  pal_g;
    logic [7:0]  pal_b;
  } raster_beat_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  len;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        done;
  } span_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // data_byte, palette_index, red, green, blue
  logic        s_axis_tuser = 1'b0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // pixel_x, pixel_y, span_length, red, green, blue
  logic        m_axis_tuser;  // image_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  always #5 clk = ~clk;

  bmp_raster_decoder dut (.*);

  // ---------------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------------
  logic [1:0]  mode_q;
  int unsigned width_q, height_q;
  logic [23:0] palette [256];
  logic [2:0]  phase;
  int unsigned run_count, abs_left, delta_cols;
  bit          abs_odd, image_finished;
  int unsigned col, row, row_bytes, byte_pos;
  logic [15:0] held;

  span_t       expected_spans[$];
  raster_beat_t pending_beats[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0, receiver_stall_pct = 0;
  bit          hold_sender = 1'b0;
  bit          input_done = 1'b0;
  int          quiet_cycles = 0;
  int          beats_added = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic void restart_raster();
    phase = PH_COUNT;
    run_count = 0; abs_left = 0; abs_odd = 0; delta_cols = 0;
    col = 0; row = clamp_dim(height_q) - 1;
    row_bytes = 0; byte_pos = 0; held = '0; image_finished = 0;
  endfunction

  function automatic void push_span(int unsigned x, int unsigned y, int unsigned len,
                                    logic [23:0] rgb, bit done);
    span_t s;
    s.x = x[11:0]; s.y = y[11:0]; s.len = len[7:0];
    s.r = rgb[23:16]; s.g = rgb[15:8]; s.b = rgb[7:0]; s.done = done;
    expected_spans.push_back(s);
  endfunction

  function automatic void push_end_marker();
    image_finished = 1;
    push_span(0, 0, 0, '0, 1'b1);
  endfunction

  function automatic void predict_plain(logic [7:0] b);
    int unsigned w, bpp, stride;
    logic [23:0] rgb;
    logic [7:0]  b0, b1, rr, gg, bb;
    bit done;
    w = clamp_dim(width_q);
    bpp = (mode_q == MODE_PAL8) ? 1 : (mode_q == MODE_RGB555) ? 2 : 3;
    stride = (w * bpp + 3) & ~32'd3;
    if (col < w) begin
      if (byte_pos + 1 >= bpp) begin
        b0 = held[7:0]; b1 = held[15:8];
        if (bpp == 1) rgb = palette[b];
        else if (bpp == 2) begin
          rr = {b[6:2], 3'b000};
          gg = {b[1:0], b0[7:5], 3'b000};
          bb = {b0[4:0], 3'b000};
          rgb = {rr, gg, bb};
        end else rgb = {b, b1, b0};
        done = (col + 1 == w) && (row == 0);
        push_span(col, row, 1, rgb, done);
        col++;
        byte_pos = 0; held = '0;
        if (done) image_finished = 1;
      end else begin
        if (byte_pos == 0) held = {8'h00, b};
        else held = {b, held[7:0]};
        byte_pos++;
      end
    end
    row_bytes++;
    if (!image_finished && col >= w && row_bytes >= stride) begin
      if (row > 0) row--;
      col = 0; row_bytes = 0; byte_pos = 0; held = '0;
    end
  endfunction

  function automatic void predict_rle(logic [7:0] b);
    int unsigned w, remain, len;
    w = clamp_dim(width_q);
    case (phase)
      PH_COUNT: begin
        run_count = b; phase = PH_VALUE;
      end
      PH_VALUE: begin
        phase = PH_COUNT;
        if (run_count != 0) begin
          remain = (col < w) ? w - col : 0;
          len = (run_count < remain) ? run_count : remain;
          if (len > 0) push_span(col, row, len, palette[b], 1'b0);
          col += len;
        end else if (b == 0) begin
          col = 0;
          if (row == 0) push_end_marker();
          else row--;
        end else if (b == 1) push_end_marker();
        else if (b == 2) phase = PH_DELTA_X;
        else begin
          abs_left = b; abs_odd = b[0]; phase = PH_ABS_DATA;
        end
      end
      PH_DELTA_X: begin
        delta_cols = b; phase = PH_DELTA_Y;
      end
      PH_DELTA_Y: begin
        phase = PH_COUNT;
        col += delta_cols;
        if (col > w) col = w;
        if (b > row) push_end_marker();
        else row -= b;
      end
      PH_ABS_DATA: begin
        if (col < w) begin
          push_span(col, row, 1, palette[b], 1'b0);
          col++;
        end
        abs_left = (abs_left - 1) & 8'hff;
        if (abs_left == 0) phase = abs_odd ? PH_ABS_PAD : PH_COUNT;
      end
      default: phase = PH_COUNT;
    endcase
  endfunction

  function automatic void predict_beat(raster_beat_t t);
    if (t.kind) begin
      palette[t.pal_idx] = {t.pal_r, t.pal_g, t.pal_b};
    end else if (!image_finished) begin
      if (mode_q == MODE_RLE8) predict_rle(t.data_byte);
      else predict_plain(t.data_byte);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat per accepted handshake, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    raster_beat_t sent;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent.kind = s_axis_tuser;
        sent.data_byte = s_axis_tdata[7:0];
        sent.pal_idx = s_axis_tdata[15:8];
        sent.pal_r = s_axis_tdata[23:16];
        sent.pal_g = s_axis_tdata[31:24];
        sent.pal_b = s_axis_tdata[39:32];
        predict_beat(sent);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          raster_beat_t t;
          t = pending_beats.pop_front();
          s_axis_tuser <= t.kind;
          s_axis_tdata <= {t.pal_b, t.pal_g, t.pal_r, t.pal_idx, t.data_byte};
          s_axis_tvalid <= 1'b1;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall and monitor
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    span_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[11:0];   got.y = m_axis_tdata[23:12];
      got.len = m_axis_tdata[31:24]; got.r = m_axis_tdata[39:32];
      got.g = m_axis_tdata[47:40];  got.b = m_axis_tdata[55:48];
      got.done = m_axis_tuser;
      if (expected_spans.size() == 0) report_mismatch("unexpected span x", got.x, -1);
      else begin
        want = expected_spans.pop_front();
        if (got.x != want.x) report_mismatch("pixel_x", got.x, want.x);
        if (got.y != want.y) report_mismatch("pixel_y", got.y, want.y);
        if (got.len != want.len) report_mismatch("span_length", got.len, want.len);
        if (got.r != want.r) report_mismatch("red", got.r, want.r);
        if (got.g != want.g) report_mismatch("green", got.g, want.g);
        if (got.b != want.b) report_mismatch("blue", got.b, want.b);
        if (got.done != want.done) report_mismatch("image_done", got.done, want.done);
      end
    end
  end

  // Watchdog: counts cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || (input_done && expected_spans.size() == 0))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    raster_beat_t t;
    t.kind = 1'b0; t.data_byte = b;
    t.pal_idx = $urandom; t.pal_r = $urandom; t.pal_g = $urandom; t.pal_b = $urandom;
    pending_beats.push_back(t);
    beats_added++;
  endfunction

  function automatic void add_palette(logic [7:0] idx, logic [23:0] rgb);
    raster_beat_t t;
    t.kind = 1'b1; t.data_byte = $urandom; t.pal_idx = idx;
    {t.pal_r, t.pal_g, t.pal_b} = rgb;
    pending_beats.push_back(t);
    beats_added++;
  endfunction

  // Wait until every queued beat is sent and every span has come back.
  task automatic drain();
    while (pending_beats.size() > 0) @(posedge clk);
    @(posedge clk);
    while (s_axis_tvalid) @(posedge clk);
    while (expected_spans.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_index <= idx;
    cfg_data <= value[12:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MODE) mode_q = value[1:0];
    else if (idx == REG_WIDTH) width_q = value[12:0];
    else height_q = value[12:0];
    restart_raster();
  endtask

  task automatic set_image(logic [1:0] m, int unsigned w, int unsigned h);
    write_reg(REG_MODE, m);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Random RLE8 stream: mostly well-formed commands, some escapes and noise.
  function automatic void add_rle_image(int unsigned cmds);
    int unsigned n;
    for (int i = 0; i < cmds; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          add_byte($urandom_range(1, 255) >> $urandom_range(5)); add_byte($urandom);
        end
        8, 9, 10, 11: begin
          n = $urandom_range(3, 9);
          add_byte(8'd0); add_byte(n);
          for (int k = 0; k < n; k++) add_byte($urandom);
          if (n[0]) add_byte($urandom);
        end
        12, 13, 14: begin add_byte(8'd0); add_byte(8'd0); end
        15, 16: begin
          add_byte(8'd0); add_byte(8'd2); add_byte($urandom_range(12)); add_byte($urandom_range(2));
        end
        17: begin add_byte(8'd0); add_byte(8'd1); end
        default: add_byte($urandom);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w, h, nbytes;
    logic [1:0] m;
    for (int i = 0; i < 256; i++) palette[i] = '0;
    mode_q = MODE_PAL8; width_q = 1; height_q = 1;
    restart_raster();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every palette entry first so no unwritten entry is ever read.
    add_palette(8'h00, 24'h000000);
    add_palette(8'hff, 24'hffffff);
    for (int i = 1; i < 255; i++) add_palette(i, $urandom);
    drain();

    // Directed: palettized 3x2 with padding
    set_image(MODE_PAL8, 3, 2);
    for (int i = 0; i < 8; i++) add_byte(i == 0 ? 8'hff : i);
    drain();
    // RGB555 extremes, 1x1
    set_image(MODE_RGB555, 1, 1);
    add_byte(8'hff); add_byte(8'hff); add_byte(8'h00);
    drain();
    // BGR 2x1
    set_image(MODE_BGR24, 2, 1);
    for (int i = 0; i < 6; i++) add_byte(i[0] ? 8'h00 : 8'hff);
    drain();
    // RLE8: clipped run, absolute odd with pad, delta, EOL, EOB
    set_image(MODE_RLE8, 4, 3);
    add_byte(8'd255); add_byte(8'd7);
    add_byte(8'd0); add_byte(8'd0);
    add_byte(8'd0); add_byte(8'd3); add_byte(8'd1); add_byte(8'd2); add_byte(8'd3);
    add_byte(8'd0);
    add_byte(8'd0); add_byte(8'd2); add_byte(8'd255); add_byte(8'd1);
    add_byte(8'd0); add_byte(8'd1);
    add_byte(8'd9);  // ignored after finish
    drain();
    // Delta steps at the largest size
    set_image(MODE_RLE8, 4096, 4096);
    add_byte(8'd0); add_byte(8'd2); add_byte(8'd0); add_byte(8'd255);
    add_byte(8'd0); add_byte(8'd2); add_byte(8'd10); add_byte(8'd255);
    drain();
    // Out-of-range sizes clamp
    set_image(MODE_PAL8, 0, 8191);
    add_byte(8'd5); add_byte(8'd6);
    drain();

    // Random phases
    for (int phase_no = 0; beats_added < 1550; phase_no++) begin
      case (phase_no % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 47; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 47; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      m = $urandom_range(3);
      w = ($urandom_range(9) == 0) ? 4096 : $urandom_range(1, 9);
      h = ($urandom_range(9) == 0) ? 4096 : $urandom_range(1, 4);
      set_image(m, w, h);
      if ($urandom_range(3) == 0) add_palette($urandom, $urandom);
      if (m == MODE_RLE8) add_rle_image($urandom_range(4, 20));
      else begin
        nbytes = $urandom_range(8, 60);
        for (int i = 0; i < nbytes; i++) add_byte($urandom);
      end
      if (phase_no == 3) begin
        // hold the sender until the block has fully drained
        while (pending_beats.size() > 40) @(posedge clk);
        hold_sender = 1'b1;
        @(posedge clk);
        while (s_axis_tvalid || expected_spans.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    input_done = 1'b1;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_spans.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/bmp_pkg.sv
rtl/bmp_parse.sv
rtl/bmp_out.sv
rtl/bmp_raster_decoder.sv
rtl/bmp_checker.sv
verif/testbench.sv
